[src/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, sizes and status codes of the delta timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

   localparam int ENTRIES    = 8;
   localparam int DELAY_BITS = 16;
   localparam int REQ_DELAY_W = 16;
   localparam int OWNER_W    = 8;
   localparam int STATUS_W   = 2;

   localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

   localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXPIRED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct packed {
      logic                  valid;
      logic [DELAY_BITS-1:0] delta;
      logic [OWNER_W-1:0]    owner;
   } entry_type;

   typedef struct packed {
      logic                  act;
      logic                  carry;
      logic [DELAY_BITS-1:0] delta;
      logic [OWNER_W-1:0]    owner;
   } token_type;

   typedef struct packed {
      logic pop;
      logic decr;
   } cell_cmd_type;

   function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [REQ_DELAY_W-1:0] d);
      logic [32:0] wide;
      wide = 33'(d);
      if (wide > 33'(DELAY_MAX)) begin
         wide = 33'(DELAY_MAX);
      end
      return DELAY_BITS'(wide);
   endfunction

endpackage

`default_nettype wire

[src/dtq_cell.sv]
// ----------------------------------------------------------------------------
// dtq_cell
// One place of the ordered timer list with the insert token stage in front.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dtq_pkg::cell_cmd_type cmd,
   input  wire dtq_pkg::entry_type    right_entry,
   input  wire dtq_pkg::token_type    tok_in,
   output dtq_pkg::token_type         tok_out,
   output dtq_pkg::entry_type         entry,
   output logic                       tok_busy
);

   dtq_pkg::entry_type entry_ff, entry_in;
   dtq_pkg::token_type tok_ff;

   always_comb begin
      entry_in = entry_ff;
      tok_out  = '0;
      if (cmd.pop) begin
         entry_in = right_entry;
      end else if (cmd.decr) begin
         entry_in.delta = entry_ff.delta - dtq_pkg::DELAY_BITS'(1);
      end else if (tok_ff.act) begin
         if (!tok_ff.carry && entry_ff.valid && (entry_ff.delta <= tok_ff.delta)) begin
            tok_out       = tok_ff;
            tok_out.delta = tok_ff.delta - entry_ff.delta;
         end else begin
            entry_in.valid = 1'b1;
            entry_in.delta = tok_ff.delta;
            entry_in.owner = tok_ff.owner;
            if (entry_ff.valid) begin
               tok_out.act   = 1'b1;
               tok_out.carry = 1'b1;
               tok_out.owner = entry_ff.owner;
               tok_out.delta = tok_ff.carry ? entry_ff.delta
                                            : entry_ff.delta - tok_ff.delta;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff         <= '0;
         entry_ff.valid <= 1'b0;
      end else begin
         tok_ff         <= tok_in;
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.delta <= entry_in.delta;
      entry_ff.owner <= entry_in.owner;
   end

   assign entry    = entry_ff;
   assign tok_busy = tok_ff.act;

endmodule

`default_nettype wire

[src/delta_timer_queue.sv]
// ----------------------------------------------------------------------------
// delta_timer_queue
// Timer queue kept as a row of cells in expiry order, head in cell 0.
//
//   Channel   Ports                                           Handshake
//   request   req_opcode, req_delay_ticks, req_owner_id       start && !busy
//   response  rsp_status, rsp_expired_owner                   rsp_strobe, one cycle
//
// Every item gives its response on the cycle after it is accepted.
// A tick leaves busy low. An insert that finds room keeps busy high while
// its token walks the cells, so no new item is taken until the token is
// through; an insert into a full queue leaves busy low. Reset empties the
// queue at once. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_timer_queue (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_opcode,
   input  wire logic [dtq_pkg::REQ_DELAY_W-1:0]    req_delay_ticks,
   input  wire logic [dtq_pkg::OWNER_W-1:0]        req_owner_id,
   output logic                                    rsp_strobe,
   output logic [dtq_pkg::STATUS_W-1:0]            rsp_status,
   output logic [dtq_pkg::OWNER_W-1:0]             rsp_expired_owner
);

   localparam int N = dtq_pkg::ENTRIES;

   dtq_pkg::entry_type    entries [N+1];
   dtq_pkg::token_type    tok_link [N+1];
   dtq_pkg::token_type    tok_head;
   dtq_pkg::cell_cmd_type cmds [N];
   logic [N-1:0]          cell_busy;

   logic                           accept, full, head_valid, head_zero;
   logic                           tick_pop, tick_decr;
   logic                           rsp_strobe_ff;
   logic [dtq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [dtq_pkg::OWNER_W-1:0]    rsp_owner_ff, rsp_owner_in;

   assign accept     = start && !busy;
   assign full       = entries[N-1].valid;
   assign head_valid = entries[0].valid;
   assign head_zero  = (entries[0].delta == '0);
   assign tick_pop   = accept && (req_opcode == dtq_pkg::OP_TICK) && head_valid && head_zero;
   assign tick_decr  = accept && (req_opcode == dtq_pkg::OP_TICK) && head_valid && !head_zero;

   assign entries[N] = '0;

   always_comb begin
      tok_head = '0;
      if (accept && (req_opcode == dtq_pkg::OP_INSERT) && !full) begin
         tok_head.act   = 1'b1;
         tok_head.carry = 1'b0;
         tok_head.delta = dtq_pkg::sat_delay(req_delay_ticks);
         tok_head.owner = req_owner_id;
      end
   end

   assign tok_link[0] = tok_head;

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign cmds[i].pop  = tick_pop;
      assign cmds[i].decr = tick_decr && (i == 0);

      dtq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmds[i]),
         .right_entry (entries[i+1]),
         .tok_in      (tok_link[i]),
         .tok_out     (tok_link[i+1]),
         .entry       (entries[i]),
         .tok_busy    (cell_busy[i])
      );
   end

   assign busy = (|cell_busy) || tok_link[N].act;

   always_comb begin
      rsp_status_in = dtq_pkg::STATUS_NONE;
      rsp_owner_in  = '0;
      if (req_opcode == dtq_pkg::OP_INSERT) begin
         rsp_status_in = full ? dtq_pkg::STATUS_FULL : dtq_pkg::STATUS_INSERTED;
      end else if (tick_pop) begin
         rsp_status_in = dtq_pkg::STATUS_EXPIRED;
         rsp_owner_in  = entries[0].owner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
      end
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_owner_ff  <= rsp_owner_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired_owner = rsp_owner_ff;

endmodule

`default_nettype wire

[src/dtq_checker.sv]
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks of the delta timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             req_opcode,
   input wire logic                             rsp_strobe,
   input wire logic [dtq_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic [dtq_pkg::OWNER_W-1:0]      rsp_expired_owner
);

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("no response after an accepted item");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("response without an accepted item");

   a_owner_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != dtq_pkg::STATUS_EXPIRED)) |-> (rsp_expired_owner == '0))
      else $error("owner reported without expiry");

   a_tick_not_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == dtq_pkg::OP_TICK)) |=> !busy)
      else $error("tick left the queue busy");

   a_insert_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == dtq_pkg::OP_INSERT))
         |=> (busy == (rsp_status == dtq_pkg::STATUS_INSERTED)))
      else $error("insert busy does not match its status");

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_opcode        (req_opcode),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_expired_owner (rsp_expired_owner)
);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the delta timer queue. Tick and insert items are
// sent through the start/busy handshake, a predictor keeps its own copy of
// the delta list, and every response is compared with the expected item.
// Directed items cover the empty, full, tie and insert-before-head cases;
// random fill and drain bursts with random sender gaps follow.
// ----------------------------------------------------------------------------

module testbench;

   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic [dtq_pkg::STATUS_W-1:0] status;
      logic [dtq_pkg::OWNER_W-1:0]  owner;
   } timer_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_opcode = dtq_pkg::OP_TICK;
   logic [dtq_pkg::REQ_DELAY_W-1:0] req_delay_ticks = '0;
   logic [dtq_pkg::OWNER_W-1:0]     req_owner_id = '0;
   logic                            rsp_strobe;
   logic [dtq_pkg::STATUS_W-1:0]    rsp_status;
   logic [dtq_pkg::OWNER_W-1:0]     rsp_expired_owner;

   logic [dtq_pkg::DELAY_BITS-1:0]  slot_delta [dtq_pkg::ENTRIES];
   logic [dtq_pkg::OWNER_W-1:0]     slot_owner [dtq_pkg::ENTRIES];
   int                              slot_next [dtq_pkg::ENTRIES];
   logic                            slot_used [dtq_pkg::ENTRIES];
   int                              head_slot;

   timer_result_type       pending_results [$];
   timer_result_type       actual_result;
   timer_result_type       oldest_result;
   timer_result_type       new_result;
   int                     error_count = 0;
   int                     quiet_cycles = 0;

   delta_timer_queue u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_delay_ticks   (req_delay_ticks),
      .req_owner_id      (req_owner_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_expired_owner (rsp_expired_owner)
   );

   always #2 clock = ~clock;

   function automatic void clear_timer_list();
      for (int i = 0; i < dtq_pkg::ENTRIES; i++) begin
         slot_delta[i] = '0;
         slot_owner[i] = '0;
         slot_next[i]  = dtq_pkg::ENTRIES;
         slot_used[i]  = 1'b0;
      end
      head_slot = dtq_pkg::ENTRIES;
   endfunction

   function automatic void apply_timer_item(input logic op,
                                            input logic [dtq_pkg::REQ_DELAY_W-1:0] delay,
                                            input logic [dtq_pkg::OWNER_W-1:0] owner,
                                            output timer_result_type res);
      int                             free_slot;
      int                             prev;
      int                             cur;
      int                             steps;
      int                             h;
      logic [dtq_pkg::DELAY_BITS-1:0] rem;
      res.status = dtq_pkg::STATUS_NONE;
      res.owner  = '0;
      if (op == dtq_pkg::OP_INSERT) begin
         free_slot = dtq_pkg::ENTRIES;
         for (int i = dtq_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!slot_used[i]) begin
               free_slot = i;
            end
         end
         if (free_slot == dtq_pkg::ENTRIES) begin
            res.status = dtq_pkg::STATUS_FULL;
         end else begin
            if (33'(delay) > 33'(dtq_pkg::DELAY_MAX)) begin
               rem = dtq_pkg::DELAY_MAX;
            end else begin
               rem = dtq_pkg::DELAY_BITS'(delay);
            end
            // Walk past every entry that expires no later than the new one.
            prev  = dtq_pkg::ENTRIES;
            cur   = head_slot;
            steps = 0;
            while (cur < dtq_pkg::ENTRIES && steps < dtq_pkg::ENTRIES
                   && slot_delta[cur] <= rem) begin
               rem   = rem - slot_delta[cur];
               prev  = cur;
               cur   = slot_next[cur];
               steps = steps + 1;
            end
            slot_used[free_slot]  = 1'b1;
            slot_owner[free_slot] = owner;
            slot_delta[free_slot] = rem;
            slot_next[free_slot]  = cur;
            if (cur < dtq_pkg::ENTRIES) begin
               slot_delta[cur] = slot_delta[cur] - rem;
            end
            if (prev < dtq_pkg::ENTRIES) begin
               slot_next[prev] = free_slot;
            end else begin
               head_slot = free_slot;
            end
            res.status = dtq_pkg::STATUS_INSERTED;
         end
      end else if (head_slot < dtq_pkg::ENTRIES) begin
         h = head_slot;
         if (slot_delta[h] != '0) begin
            slot_delta[h] = slot_delta[h] - dtq_pkg::DELAY_BITS'(1);
         end else begin
            res.status    = dtq_pkg::STATUS_EXPIRED;
            res.owner     = slot_owner[h];
            head_slot     = slot_next[h];
            slot_next[h]  = dtq_pkg::ENTRIES;
            slot_delta[h] = '0;
            slot_owner[h] = '0;
            slot_used[h]  = 1'b0;
         end
      end
   endfunction

   // Responses are checked before the item accepted at the same edge is predicted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            actual_result.status = rsp_status;
            actual_result.owner  = rsp_expired_owner;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected response, status %0d, owner %0d", $time,
                        actual_result.status, actual_result.owner);
               error_count++;
            end else begin
               oldest_result = pending_results.pop_front();
               if (actual_result.status !== oldest_result.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                           oldest_result.status, actual_result.status);
                  error_count++;
               end
               if (actual_result.owner !== oldest_result.owner) begin
                  $display("%0t: expired owner mismatch, expected %0d, actual %0d", $time,
                           oldest_result.owner, actual_result.owner);
                  error_count++;
               end
            end
         end
         if (start && busy === 1'b0) begin
            apply_timer_item(req_opcode, req_delay_ticks, req_owner_id, new_result);
            pending_results.push_back(new_result);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic op, input logic [dtq_pkg::REQ_DELAY_W-1:0] delay,
                            input logic [dtq_pkg::OWNER_W-1:0] owner);
      @(negedge clock);
      start           <= 1'b1;
      req_opcode      <= op;
      req_delay_ticks <= delay;
      req_owner_id    <= owner;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start           <= 1'b0;
         req_opcode      <= 1'($urandom);
         req_delay_ticks <= dtq_pkg::REQ_DELAY_W'($urandom);
         req_owner_id    <= dtq_pkg::OWNER_W'($urandom);
      end
   endtask

   task automatic maybe_pause();
      if ($urandom_range(0, 3) == 0) begin
         pause_sender($urandom_range(1, 19));
      end
   endtask

   task automatic send_tick();
      send_item(dtq_pkg::OP_TICK, dtq_pkg::REQ_DELAY_W'($urandom),
                dtq_pkg::OWNER_W'($urandom));
   endtask

   task automatic send_random_insert();
      int                              pick;
      logic [dtq_pkg::REQ_DELAY_W-1:0] delay;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
         delay = dtq_pkg::REQ_DELAY_W'($urandom_range(0, 7));
      end else if (pick < 19) begin
         delay = dtq_pkg::REQ_DELAY_W'($urandom_range(8, 40));
      end else begin
         delay = dtq_pkg::REQ_DELAY_W'($urandom_range(41, 100));
      end
      send_item(dtq_pkg::OP_INSERT, delay, dtq_pkg::OWNER_W'($urandom));
   endtask

   task automatic test_empty_tick();
      send_item(dtq_pkg::OP_TICK, '1, '1);
      send_item(dtq_pkg::OP_TICK, '0, '0);
   endtask

   task automatic test_insert_order();
      send_item(dtq_pkg::OP_INSERT, 16'd10, 8'h01);
      send_item(dtq_pkg::OP_INSERT, 16'd10, 8'h02);
      maybe_pause();
      send_item(dtq_pkg::OP_INSERT, 16'd3, 8'h03);
      send_item(dtq_pkg::OP_INSERT, 16'd0, 8'h00);
      send_item(dtq_pkg::OP_INSERT, '1, 8'hFF);
      maybe_pause();
      send_item(dtq_pkg::OP_INSERT, 16'd12, 8'h04);
      send_item(dtq_pkg::OP_INSERT, 16'd0, 8'h05);
      send_item(dtq_pkg::OP_INSERT, 16'd20, 8'hAA);
      send_item(dtq_pkg::OP_INSERT, 16'd1, 8'h55);
      send_item(dtq_pkg::OP_INSERT, 16'h8000, 8'h80);
   endtask

   task automatic test_expiry();
      repeat (12) begin
         send_tick();
         maybe_pause();
      end
   endtask

   task automatic test_fill_and_drain(input int items);
      int sent;
      int burst;
      int insert_weight;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(0, 2))
            0: insert_weight = 80;
            1: insert_weight = 15;
            default: insert_weight = 50;
         endcase
         burst = $urandom_range(4, 20);
         while (burst > 0 && sent < items) begin
            if ($urandom_range(1, 100) <= insert_weight) begin
               send_random_insert();
            end else begin
               send_tick();
            end
            maybe_pause();
            burst--;
            sent++;
         end
      end
   endtask

   task automatic test_back_to_back(input int items);
      repeat (items) begin
         if ($urandom_range(0, 1) == 0) begin
            send_random_insert();
         end else begin
            send_tick();
         end
      end
   endtask

   initial begin
      clear_timer_list();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_tick();
      test_insert_order();
      test_expiry();
      test_fill_and_drain(330);
      test_back_to_back(100);
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * dtq_pkg::ENTRIES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/dtq_pkg.sv
src/dtq_cell.sv
src/delta_timer_queue.sv
src/dtq_checker.sv
test/testbench.sv
